FILE: sv/bdq_pkg.sv
// Shared types and constants for the bounded deque.
package bdq_pkg;

	localparam int DATA_W = 32;
	localparam int FUNC_W = 3;
	localparam int POS_W  = 5;
	localparam int OCC_W  = 5;
	localparam int STAT_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_DELETE_AT  = 3'd4,
		FN_READ_AT    = 3'd5,
		FN_PEEK_FRONT = 3'd6,
		FN_PEEK_BACK  = 3'd7
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD       = 2'd0,
		CELL_PUSH_FRONT = 2'd1,
		CELL_WRITE      = 2'd2,
		CELL_REMOVE     = 2'd3
	} cell_op_t;

endpackage

FILE: sv/bounded_deque_with_positional_ops_top.sv
// Top level of the bounded deque: request decode, cell chain and result register.
//
//  channel | handshake            | word
//  in      | in_valid / in_stall  | func, value, position
//  out     | out_valid / out_stall| result_value, occupancy, status
//
// One request per cycle while in_stall is low; a result appears in the cycle after acceptance.
// The chain of DEPTH cells shifts its entries in parallel.
// Reset empties the queue; cell contents are not cleared.
// A held result stalls the input only while out_stall is high.
module bounded_deque_with_positional_ops_top #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bdq_pkg::FUNC_W-1:0]        func,
	input  logic signed [bdq_pkg::DATA_W-1:0] value,
	input  logic [bdq_pkg::POS_W-1:0]         position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [bdq_pkg::DATA_W-1:0] result_value,
	output logic [bdq_pkg::OCC_W-1:0]         occupancy,
	output logic [bdq_pkg::STAT_W-1:0]        status
);
	import bdq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > POS_W) ? ((CNT_W > OCC_W) ? CNT_W : OCC_W)
	                                       : ((POS_W > OCC_W) ? POS_W : OCC_W);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] result_value_q;
	logic [OCC_W-1:0]         occupancy_q;
	status_t                  status_q;

	logic signed [DATA_W-1:0] cell_q   [DEPTH];
	logic signed [DATA_W-1:0] cell_tap [DEPTH];

	cell_op_t                 cell_op;
	logic [IDX_W-1:0]         wr_idx;
	logic [IDX_W-1:0]         rd_idx;
	logic signed [DATA_W-1:0] rd_data;
	logic signed [DATA_W-1:0] res;
	status_t                  st;

	logic             accept;
	logic             full;
	logic             empty;
	logic             pos_ok;
	logic [CMP_W-1:0] pos_m1;
	logic [CMP_W-1:0] back_m1;
	logic [CMP_W-1:0] count_ext;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign count_ext = CMP_W'(count_q);
	assign pos_ok    = (position != '0) && (CMP_W'(position) <= count_ext);
	assign pos_m1    = CMP_W'(position) - CMP_W'(1);
	assign back_m1   = count_ext - CMP_W'(1);

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_data = rd_data | cell_tap[i];
		end
	end

	always_comb begin
		cell_op = CELL_HOLD;
		wr_idx  = '0;
		rd_idx  = '0;
		count_d = count_q;
		st      = ST_OK;
		res     = '0;
		case (func_t'(func))
			FN_PUSH_FRONT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					cell_op = CELL_PUSH_FRONT;
					count_d = count_q + CNT_W'(1);
				end
			end
			FN_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					cell_op = CELL_WRITE;
					wr_idx  = count_ext[IDX_W-1:0];
					count_d = count_q + CNT_W'(1);
				end
			end
			FN_POP_FRONT: begin
				if (empty) begin
					st = ST_BAD;
				end else begin
					cell_op = CELL_REMOVE;
					count_d = count_q - CNT_W'(1);
					res     = rd_data;
				end
			end
			FN_POP_BACK: begin
				rd_idx = back_m1[IDX_W-1:0];
				if (empty) begin
					st = ST_BAD;
				end else begin
					count_d = count_q - CNT_W'(1);
					res     = rd_data;
				end
			end
			FN_DELETE_AT: begin
				rd_idx = pos_m1[IDX_W-1:0];
				wr_idx = pos_m1[IDX_W-1:0];
				if (!pos_ok) begin
					st = ST_BAD;
				end else begin
					cell_op = CELL_REMOVE;
					count_d = count_q - CNT_W'(1);
					res     = rd_data;
				end
			end
			FN_READ_AT: begin
				rd_idx = pos_m1[IDX_W-1:0];
				if (!pos_ok) begin
					st = ST_BAD;
				end else begin
					res = rd_data;
				end
			end
			FN_PEEK_FRONT: begin
				if (empty) begin
					st = ST_BAD;
				end else begin
					res = rd_data;
				end
			end
			FN_PEEK_BACK: begin
				rd_idx = back_m1[IDX_W-1:0];
				if (empty) begin
					st = ST_BAD;
				end else begin
					res = rd_data;
				end
			end
			default: begin
				st = ST_BAD;
			end
		endcase
		if (!accept) begin
			cell_op = CELL_HOLD;
			count_d = count_q;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;

		if (g == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_q[g+1];
		end

		bdq_cell #(
			.IDX_W (IDX_W),
			.INDEX (g)
		) u_cell (
			.clk     (clk),
			.op      (cell_op),
			.wr_idx  (wr_idx),
			.rd_idx  (rd_idx),
			.din     (value),
			.left_d  (left_d),
			.right_d (right_d),
			.q       (cell_q[g]),
			.tap     (cell_tap[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_value_q <= res;
			occupancy_q    <= OCC_W'(CMP_W'(count_d));
			status_q       <= st;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign occupancy    = occupancy_q;
	assign status       = status_q;

endmodule

FILE: sv/bdq_cell.sv
// One storage cell of the deque chain.
module bdq_cell #(
	parameter int IDX_W = 4,
	parameter int INDEX = 0
) (
	input  logic                            clk,
	input  bdq_pkg::cell_op_t               op,
	input  logic [IDX_W-1:0]                wr_idx,
	input  logic [IDX_W-1:0]                rd_idx,
	input  logic signed [bdq_pkg::DATA_W-1:0] din,
	input  logic signed [bdq_pkg::DATA_W-1:0] left_d,
	input  logic signed [bdq_pkg::DATA_W-1:0] right_d,
	output logic signed [bdq_pkg::DATA_W-1:0] q,
	output logic signed [bdq_pkg::DATA_W-1:0] tap
);
	import bdq_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (op)
			CELL_PUSH_FRONT: begin
				data_d = (wr_idx == MY_IDX) ? din : left_d;
			end
			CELL_WRITE: begin
				if (wr_idx == MY_IDX) begin
					data_d = din;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= wr_idx) begin
					data_d = right_d;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign q   = data_q;
	assign tap = (rd_idx == MY_IDX) ? data_q : '0;

endmodule
